### rtl/rbeu_pkg.sv
// Package: shared types, operation codes, tables and float helpers for the execute unit
package rbeu_pkg;

	localparam int REG_COUNT = 256;
	localparam int IDX_W = $clog2(REG_COUNT);

	// operation codes
	localparam logic [5:0] MODE_LDI       = 6'd0;
	localparam logic [5:0] MODE_SGN_LAST  = 6'd11;
	localparam logic [5:0] MODE_CVT_LAST  = 6'd28;
	localparam logic [5:0] MODE_F32TO64   = 6'd29;
	localparam logic [5:0] MODE_ADD_FIRST = 6'd30;
	localparam logic [5:0] MODE_SUB_FIRST = 6'd40;
	localparam logic [5:0] MODE_SUB_LAST  = 6'd49;
	localparam logic [5:0] MODE_RET       = 6'd50;

	// kind of an add/subtract, counted from its first code
	localparam logic [5:0] KIND_F32 = 6'd8;
	localparam logic [5:0] KIND_F64 = 6'd9;

	// integer width codes
	localparam logic [1:0] W8  = 2'd0;
	localparam logic [1:0] W16 = 2'd1;
	localparam logic [1:0] W32 = 2'd2;
	localparam logic [1:0] W64 = 2'd3;

	// float value classes
	localparam logic [1:0] CLS_ZERO = 2'd0;
	localparam logic [1:0] CLS_FIN  = 2'd1;
	localparam logic [1:0] CLS_INF  = 2'd2;
	localparam logic [1:0] CLS_NAN  = 2'd3;

	localparam logic signed [12:0] ZERO_E = -13'sd2100;
	localparam logic [63:0] DEF_NAN = 64'hFFF8_0000_0000_0000;

	// source width per conversion code
	localparam logic [1:0] CVT_WC [0:28] = '{
		W64, W8, W8, W8, W8, W8, W16, W16, W16, W16, W32, W32,
		W8, W8, W8, W8, W8, W8, W8, W8, W16, W16, W16, W16, W16, W16, W32, W32, W32
	};
	// destination is a double, per conversion code
	localparam logic CVT_FLT [0:28] = '{
		1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
		1'b1, 1'b1, 1'b0, 1'b0, 1'b1
	};

	// value = m / 2^63 * 2^e; a NaN carries its final double bits in m
	typedef struct packed {
		logic [1:0]          cls;
		logic                sgn;
		logic signed [12:0]  e;
		logic [63:0]         m;
	} fpv_t;

	function automatic logic [63:0] ext_w(input logic [63:0] v, input logic [1:0] wc,
			input logic sgn);
		logic [63:0] r;
		case (wc)
			W8:      r = {{56{sgn & v[7]}}, v[7:0]};
			W16:     r = {{48{sgn & v[15]}}, v[15:0]};
			W32:     r = {{32{sgn & v[31]}}, v[31:0]};
			default: r = v;
		endcase
		return r;
	endfunction

	function automatic fpv_t unpack64(input logic [63:0] bits);
		fpv_t r;
		r.sgn = bits[63];
		r.e = ZERO_E;
		r.m = '0;
		if (bits[62:52] == 11'h7FF) begin
			r.cls = (bits[51:0] == '0) ? CLS_INF : CLS_NAN;
			r.m = (bits[51:0] == '0) ? 64'd0 : (bits | (64'd1 << 51));
		end else if (bits[62:52] == 11'd0) begin
			r.cls = (bits[51:0] == '0) ? CLS_ZERO : CLS_FIN;
			r.e = (bits[51:0] == '0) ? ZERO_E : -13'sd1022;
			r.m = {1'b0, bits[51:0], 11'd0};
		end else begin
			r.cls = CLS_FIN;
			r.e = $signed({2'b00, bits[62:52]}) - 13'sd1023;
			r.m = {1'b1, bits[51:0], 11'd0};
		end
		return r;
	endfunction

	// unpack a double ahead of rounding to single; double subnormals round to zero
	function automatic fpv_t unpack32(input logic [63:0] bits);
		fpv_t r;
		r.sgn = bits[63];
		r.e = ZERO_E;
		r.m = '0;
		if (bits[62:52] == 11'h7FF) begin
			r.cls = (bits[51:0] == '0) ? CLS_INF : CLS_NAN;
			r.m = (bits[51:0] == '0) ? 64'd0 : {bits[63], 11'h7FF, 1'b1, bits[50:29], 29'd0};
		end else if (bits[62:52] == 11'd0) begin
			r.cls = CLS_ZERO;
		end else begin
			r.cls = CLS_FIN;
			r.e = $signed({2'b00, bits[62:52]}) - 13'sd1023;
			r.m = {1'b1, bits[51:0], 11'd0};
		end
		return r;
	endfunction

	// round a normalized value to single or double, nearest even
	function automatic fpv_t round_fp(input fpv_t x, input logic is32);
		fpv_t r;
		logic signed [13:0] emin, emax, ex, under, dd;
		logic [6:0] d;
		logic [64:0] mx, unit, mask, sum;
		logic rbit, stk, lsb, up;
		r = x;
		emin = is32 ? -14'sd126 : -14'sd1022;
		emax = is32 ? 14'sd127 : 14'sd1023;
		ex = 14'(x.e);
		under = emin - ex;
		dd = (is32 ? 14'sd40 : 14'sd11) + ((under > 14'sd0) ? under : 14'sd0);
		d = dd[6:0];
		mx = {1'b0, x.m};
		unit = 65'd1 << d;
		mask = unit - 65'd1;
		rbit = |(mx & (unit >> 1));
		stk = |(mx & (mask >> 1));
		lsb = |(mx & unit);
		up = rbit & (stk | lsb);
		sum = (mx & ~mask) + (up ? unit : 65'd0);
		if (x.cls == CLS_FIN) begin
			if (dd > 14'sd64 || sum == 65'd0) begin
				r.cls = CLS_ZERO;
				r.m = '0;
			end else if (sum[64]) begin
				r.m = {1'b1, 63'd0};
				r.e = x.e + 13'sd1;
			end else begin
				r.m = sum[63:0];
			end
			if (r.cls == CLS_FIN && 14'(r.e) > emax) begin
				r.cls = CLS_INF;
				r.m = '0;
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] pack_fp(input fpv_t x, input logic is32);
		logic [63:0] r;
		logic [12:0] sh;
		logic [52:0] frac;
		logic [10:0] ef;
		sh = 13'(-13'sd1022 - x.e);
		frac = x.m[63:11] >> sh;
		ef = 11'(x.e + 13'sd1023);
		case (x.cls)
			CLS_ZERO: r = {x.sgn, 63'd0};
			CLS_INF:  r = {x.sgn, 11'h7FF, 52'd0};
			CLS_NAN:  r = x.m;
			default: begin
				if (is32 || x.e >= -13'sd1022)
					r = {x.sgn, ef, x.m[62:11]};
				else
					r = {x.sgn, 11'd0, frac[51:0]};
			end
		endcase
		return r;
	endfunction

endpackage

### rtl/register_bytecode_execute_unit.sv
// Register-machine execute unit: register file memory, integer ops and float datapath
//
// One instruction is taken at a time. Loads, integer conversions, integer add/subtract
// and returns read the register file, then execute and write back (a return fills the
// output register, waiting while it is full). Float work runs in states: conversions
// to double normalize (not a zero), round and pack; f32-to-f64 rounds and packs;
// add/subtract aligns, adds, normalizes, rounds and packs, the f32 forms first rounding
// each operand. The normalizer shifts at most eight bits per cycle. The register file is
// one memory with two synchronous read ports used at accept and one write port used at
// the end of an instruction, so back-to-back dependent instructions need no forwarding.
// It holds no reset value: a register must be written before it is read. A return beat
// waits in an output register; the next instruction is accepted while it is pending.
module register_bytecode_execute_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [5:0]  mode,
	input  logic [7:0]  dest_reg,
	input  logic [7:0]  src_a_reg,
	input  logic [7:0]  src_b_reg,
	input  logic [63:0] immediate_bits,
	input  logic [3:0]  type_tag,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] value_bits,
	output logic [3:0]  value_type
);
	import rbeu_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_EXEC  = 4'd1;
	localparam logic [3:0] ST_RA    = 4'd2;
	localparam logic [3:0] ST_RB    = 4'd3;
	localparam logic [3:0] ST_ALIGN = 4'd4;
	localparam logic [3:0] ST_ADD   = 4'd5;
	localparam logic [3:0] ST_NORM  = 4'd6;
	localparam logic [3:0] ST_RND   = 4'd7;
	localparam logic [3:0] ST_PACK  = 4'd8;

	logic [3:0]  state_q;
	logic [5:0]  mode_q;
	logic [7:0]  dest_q;
	logic [3:0]  tag_q;
	logic [63:0] imm_q;
	logic        is32_q, sub_q;
	logic [63:0] rd_a_q, rd_b_q;
	fpv_t        x_q, y_q, w_q;
	logic [63:0] big_m_q, sml_m_q;
	logic signed [12:0] add_e_q;
	logic        add_sgn_q, eff_sub_q;
	logic        out_valid_q;
	logic [63:0] value_bits_q;
	logic [3:0]  value_type_q;

	logic [63:0] mem [0:REG_COUNT-1];

	logic        in_acc;
	logic        wr_en;
	logic [63:0] wr_data;

	// decode
	logic        op_sub;
	logic [5:0]  kind;
	logic [4:0]  cvt_idx;
	logic        cvt_sgn, cvt_neg, cvt_flt;
	logic [63:0] cvt_v, cvt_mag, int_r;
	logic        is_cvt, is_arith;

	// alignment
	logic        sx, sy, xbig, spec;
	fpv_t        spec_w;
	logic signed [13:0] ex, ey, diff;
	logic [63:0] bm, smm, sh_m;
	logic        stk;
	logic [64:0] sum65;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign value_bits = value_bits_q;
	assign value_type = value_type_q;

	always_comb begin
		is_cvt = (mode_q != MODE_LDI) && (mode_q <= MODE_CVT_LAST);
		is_arith = (mode_q >= MODE_ADD_FIRST) && (mode_q <= MODE_SUB_LAST);
		op_sub = (mode_q >= MODE_SUB_FIRST);
		kind = op_sub ? (mode_q - MODE_SUB_FIRST) : (mode_q - MODE_ADD_FIRST);
		cvt_idx = is_cvt ? mode_q[4:0] : 5'd0;
		cvt_sgn = (mode_q <= MODE_SGN_LAST);
		cvt_flt = CVT_FLT[cvt_idx];
		cvt_v = ext_w(rd_a_q, CVT_WC[cvt_idx], cvt_sgn);
		cvt_neg = cvt_sgn & cvt_v[63];
		cvt_mag = cvt_neg ? (~cvt_v + 64'd1) : cvt_v;
		int_r = ext_w(op_sub ? (rd_a_q - rd_b_q) : (rd_a_q + rd_b_q), kind[1:0], !kind[2]);
	end

	// special operands and alignment of the smaller one
	always_comb begin
		sx = x_q.sgn;
		sy = y_q.sgn ^ sub_q;
		spec = 1'b1;
		spec_w = '0;
		if (x_q.cls == CLS_NAN) begin
			spec_w = x_q;
		end else if (y_q.cls == CLS_NAN) begin
			spec_w = y_q;
		end else if (x_q.cls == CLS_INF && y_q.cls == CLS_INF) begin
			spec_w.cls = (sx != sy) ? CLS_NAN : CLS_INF;
			spec_w.sgn = sx;
			spec_w.m = (sx != sy) ? DEF_NAN : 64'd0;
		end else if (x_q.cls == CLS_INF) begin
			spec_w.cls = CLS_INF;
			spec_w.sgn = sx;
		end else if (y_q.cls == CLS_INF) begin
			spec_w.cls = CLS_INF;
			spec_w.sgn = sy;
		end else if (x_q.cls == CLS_ZERO && y_q.cls == CLS_ZERO) begin
			spec_w.cls = CLS_ZERO;
			spec_w.sgn = sx & sy;
		end else begin
			spec = 1'b0;
		end
		ex = 14'((x_q.cls == CLS_ZERO) ? ZERO_E : x_q.e);
		ey = 14'((y_q.cls == CLS_ZERO) ? ZERO_E : y_q.e);
		xbig = (ex > ey) || (ex == ey && x_q.m >= y_q.m);
		diff = xbig ? (ex - ey) : (ey - ex);
		bm = xbig ? x_q.m : y_q.m;
		smm = xbig ? y_q.m : x_q.m;
		if (diff > 14'sd63) begin
			sh_m = 64'd0;
			stk = |smm;
		end else begin
			sh_m = smm >> diff[5:0];
			stk = |(smm & ((64'd1 << diff[5:0]) - 64'd1));
		end
		sum65 = eff_sub_q ? ({1'b0, big_m_q} - {1'b0, sml_m_q})
			: ({1'b0, big_m_q} + {1'b0, sml_m_q});
	end

	always_comb begin
		wr_en = 1'b0;
		wr_data = int_r;
		if (state_q == ST_EXEC) begin
			if (mode_q == MODE_LDI) begin
				wr_en = 1'b1;
				wr_data = imm_q;
			end else if (is_cvt && !cvt_flt) begin
				wr_en = 1'b1;
				wr_data = cvt_v;
			end else if (is_arith && kind < KIND_F32) begin
				wr_en = 1'b1;
				wr_data = int_r;
			end
		end else if (state_q == ST_PACK) begin
			wr_en = 1'b1;
			wr_data = pack_fp(w_q, is32_q);
		end
	end

	// register file
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[dest_q[IDX_W-1:0]] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_a_q <= mem[src_a_reg[IDX_W-1:0]];
			rd_b_q <= mem[src_b_reg[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// a return that refills the output register keeps valid high
			if (out_valid_q && out_ready && !(state_q == ST_EXEC && mode_q == MODE_RET))
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						mode_q <= mode;
						dest_q <= dest_reg;
						tag_q <= type_tag;
						imm_q <= immediate_bits;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					sub_q <= op_sub;
					if (is_cvt && cvt_flt) begin
						w_q.cls <= (cvt_mag == 64'd0) ? CLS_ZERO : CLS_FIN;
						w_q.sgn <= cvt_neg;
						w_q.e <= 13'sd63;
						w_q.m <= cvt_mag;
						is32_q <= 1'b0;
						state_q <= (cvt_mag == 64'd0) ? ST_RND : ST_NORM;
					end else if (mode_q == MODE_F32TO64) begin
						w_q <= unpack32(rd_a_q);
						is32_q <= 1'b1;
						state_q <= ST_RND;
					end else if (is_arith && kind == KIND_F32) begin
						x_q <= unpack32(rd_a_q);
						y_q <= unpack32(rd_b_q);
						is32_q <= 1'b1;
						state_q <= ST_RA;
					end else if (is_arith && kind == KIND_F64) begin
						x_q <= unpack64(rd_a_q);
						y_q <= unpack64(rd_b_q);
						is32_q <= 1'b0;
						state_q <= ST_ALIGN;
					end else if (mode_q == MODE_RET) begin
						// hold until the output register is free
						if (!out_valid_q || out_ready) begin
							out_valid_q <= 1'b1;
							value_bits_q <= rd_a_q;
							value_type_q <= tag_q;
							state_q <= ST_IDLE;
						end
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_RA: begin
					x_q <= round_fp(x_q, 1'b1);
					state_q <= ST_RB;
				end
				ST_RB: begin
					y_q <= round_fp(y_q, 1'b1);
					state_q <= ST_ALIGN;
				end
				ST_ALIGN: begin
					if (spec) begin
						w_q <= spec_w;
						state_q <= ST_RND;
					end else begin
						big_m_q <= bm;
						sml_m_q <= sh_m | {63'd0, stk};
						add_e_q <= xbig ? x_q.e : y_q.e;
						add_sgn_q <= xbig ? sx : sy;
						eff_sub_q <= sx ^ sy;
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (sum65 == 65'd0) begin
						// exact cancellation gives +0
						w_q.cls <= CLS_ZERO;
						w_q.sgn <= 1'b0;
						w_q.m <= 64'd0;
						state_q <= ST_RND;
					end else if (sum65[64]) begin
						w_q.cls <= CLS_FIN;
						w_q.sgn <= add_sgn_q;
						w_q.m <= sum65[64:1] | {63'd0, sum65[0]};
						w_q.e <= add_e_q + 13'sd1;
						state_q <= ST_NORM;
					end else begin
						w_q.cls <= CLS_FIN;
						w_q.sgn <= add_sgn_q;
						w_q.m <= sum65[63:0];
						w_q.e <= add_e_q;
						state_q <= ST_NORM;
					end
				end
				ST_NORM: begin
					if (w_q.cls != CLS_FIN || w_q.m[63]) begin
						state_q <= ST_RND;
					end else if (w_q.m[63:56] == 8'd0) begin
						w_q.m <= w_q.m << 8;
						w_q.e <= w_q.e - 13'sd8;
					end else begin
						w_q.m <= w_q.m << 1;
						w_q.e <= w_q.e - 13'sd1;
					end
				end
				ST_RND: begin
					w_q <= round_fp(w_q, is32_q);
					state_q <= ST_PACK;
				end
				ST_PACK: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/rbeu_checker.sv
// Checker: port-level properties of the execute unit, bound to the top level
module rbeu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [5:0]  mode,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] value_bits,
	input logic [3:0]  value_type
);
	import rbeu_pkg::*;

	// one instruction at a time: busy right after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted a beat while the previous instruction was in flight");

	// a return into an empty output register reaches out_valid through the execute state
	a_return_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && mode == MODE_RET && !out_valid |=> ##1 out_valid)
		else $error("return beat did not reach the output");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value_bits) && $stable(value_type))
		else $error("stalled output beat changed or dropped");

endmodule

bind register_bytecode_execute_unit rbeu_checker u_rbeu_checker (.*);
